@@ rtl/bbr_pkg.sv @@
package bbr_pkg;

	// valve shift-register geometry
	localparam int NUM_REGISTERS  = 4;
	localparam int REGISTER_WIDTH = 8;
	localparam int IMG_WIDTH      = 32;
	localparam int IMG_BITS       = NUM_REGISTERS * REGISTER_WIDTH;
	localparam int IMG_LIMIT      = (IMG_BITS > IMG_WIDTH) ? IMG_WIDTH : IMG_BITS;

	// field widths
	localparam int RAW_W   = 14;
	localparam int Q16_W   = 17;
	localparam int PRS_W   = 16;
	localparam int POS_W   = 6;
	localparam int IDX_W   = 3;
	localparam int CMD_W   = 2;

	// sensor transfer function
	localparam int SENSOR_OFFSET = 1638;
	localparam int SENSOR_SPAN   = 13108;
	localparam int FS_MAX        = 65535;
	// bias that lifts the scaled code above zero before the division
	localparam int CONV_BIAS     = (FS_MAX * SENSOR_OFFSET + SENSOR_SPAN - 1) / SENSOR_SPAN;
	localparam int CONV_OFFS     = CONV_BIAS * SENSOR_SPAN;
	localparam int RECIP_SHIFT   = 44;
	localparam logic [31:0] RECIP_M =
		32'((64'd1 << RECIP_SHIFT) / 64'(SENSOR_SPAN));

	localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MIN_PRESSURE = 3'd0,
		REG_MAX_PRESSURE = 3'd1,
		REG_TOLERANCE    = 3'd2,
		REG_FILTER_GAIN  = 3'd3,
		REG_FULL_SCALE   = 3'd4,
		REG_INFLATE_BIT  = 3'd5,
		REG_VACUUM_BIT   = 3'd6
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		VALVE_HOLD    = 2'd0,
		VALVE_INFLATE = 2'd1,
		VALVE_VACUUM  = 2'd2
	} valve_cmd_t;

	typedef enum logic [2:0] {
		MUL_CONV,
		MUL_RECIP,
		MUL_CORR,
		MUL_FILT,
		MUL_SETP
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_RECIP,
		ST_CORR,
		ST_QUO,
		ST_FILT,
		ST_SETP,
		ST_DEC
	} state_t;

	typedef struct packed {
		logic [PRS_W-1:0] sp_floor;
		logic [PRS_W-1:0] sp_ceil;
		logic [PRS_W-1:0] tolerance;
		logic [Q16_W-1:0] filter_gain;
		logic [PRS_W-1:0] full_scale;
		logic [POS_W-1:0] inflate_bit;
		logic [POS_W-1:0] vacuum_bit;
	} cfg_t;

	typedef struct packed {
		logic    capture;
		logic    mul_en;
		mul_op_t op;
		logic    quo_en;
		logic    filt_en;
		logic    commit;
	} bbr_cmd_t;

endpackage

@@ rtl/bbr_ifs.sv @@
interface bbr_in_if;
	import bbr_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_sample;
	logic [Q16_W-1:0] activation;
	logic             stop_when_reached;

	modport source (output valid, raw_sample, activation, stop_when_reached, input ready);
	modport sink   (input valid, raw_sample, activation, stop_when_reached, output ready);
endinterface

interface bbr_out_if;
	import bbr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     valve_command;
	logic [PRS_W-1:0]     filtered_pressure;
	logic [PRS_W-1:0]     active_setpoint;
	logic                 reached;
	logic [IMG_WIDTH-1:0] shift_image;

	modport source (output valid, valve_command, filtered_pressure, active_setpoint, reached,
		shift_image, input ready);
	modport sink   (input valid, valve_command, filtered_pressure, active_setpoint, reached,
		shift_image, output ready);
endinterface

interface bbr_cfg_if;
	import bbr_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [Q16_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bbr_ctrl.sv @@
module bbr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bbr_pkg::bbr_cmd_t cmd
);
	import bbr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '{capture: 1'b0, mul_en: 1'b0, op: MUL_CONV, quo_en: 1'b0,
			filt_en: 1'b0, commit: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.mul_en = 1'b1;
				cmd.op     = MUL_CONV;
				state_d    = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.mul_en = 1'b1;
				cmd.op     = MUL_RECIP;
				state_d    = ST_CORR;
			end
			ST_CORR: begin
				cmd.mul_en = 1'b1;
				cmd.op     = MUL_CORR;
				state_d    = ST_QUO;
			end
			ST_QUO: begin
				cmd.quo_en = 1'b1;
				state_d    = ST_FILT;
			end
			ST_FILT: begin
				cmd.mul_en = 1'b1;
				cmd.op     = MUL_FILT;
				state_d    = ST_SETP;
			end
			ST_SETP: begin
				cmd.mul_en  = 1'b1;
				cmd.op      = MUL_SETP;
				cmd.filt_en = 1'b1;
				state_d     = ST_DEC;
			end
			ST_DEC: begin
				// result slot free or emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/bbr_dpath.sv @@
module bbr_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bbr_pkg::cfg_t                 cfg,
	input  bbr_pkg::bbr_cmd_t             cmd,
	input  logic [bbr_pkg::RAW_W-1:0]     raw_sample,
	input  logic [bbr_pkg::Q16_W-1:0]     activation,
	input  logic                          stop_when_reached,
	output logic [bbr_pkg::CMD_W-1:0]     valve_command,
	output logic [bbr_pkg::PRS_W-1:0]     filtered_pressure,
	output logic [bbr_pkg::PRS_W-1:0]     active_setpoint,
	output logic                          reached,
	output logic [bbr_pkg::IMG_WIDTH-1:0] shift_image
);
	import bbr_pkg::*;

	// captured item
	logic [RAW_W-1:0] raw_q;
	logic [Q16_W-1:0] act_q;
	logic             stop_q;

	// working registers
	logic signed [63:0] prod_q;
	logic [30:0]        xoff_q;
	logic [17:0]        qest_q;
	logic signed [18:0] conv_q;
	logic [PRS_W-1:0]   filt_q;

	// regulator state
	logic [PRS_W-1:0]     est_q;
	logic [PRS_W-1:0]     held_q;
	logic                 reached_q;
	logic [IMG_WIDTH-1:0] img_q;
	valve_cmd_t           vcmd_q;

	logic signed [31:0] mul_a, mul_b;
	logic [30:0]        xoff_d;
	logic [30:0]        rem;
	logic [17:0]        quo;
	logic signed [18:0] conv_d;
	logic [Q16_W-1:0]   gain_eff, act_eff;
	logic signed [39:0] acc;
	logic [PRS_W-1:0]   filt_d;
	logic [33:0]        sp_sum;
	logic [17:0]        sp_raw;
	logic [PRS_W-1:0]   sp_lo, sp;
	logic signed [17:0] diff;
	logic [17:0]        mag;
	logic               in_band, skip;
	valve_cmd_t         vcmd_d;
	logic [IMG_WIDTH-1:0] img_d;

	assign gain_eff = cfg.filter_gain[Q16_W-1] ? ONE_Q16 : cfg.filter_gain;
	assign act_eff  = act_q[Q16_W-1] ? ONE_Q16 : act_q;

	// scaled code lifted to non-negative
	assign xoff_d = 31'(prod_q[31:0] + 32'(CONV_OFFS));

	// shared multiplier operand select
	always_comb begin
		unique case (cmd.op)
			MUL_CONV: begin
				mul_a = signed'({16'd0, cfg.full_scale});
				mul_b = signed'({18'd0, raw_q}) - signed'(32'(SENSOR_OFFSET));
			end
			MUL_RECIP: begin
				mul_a = signed'({1'b0, xoff_d});
				mul_b = signed'(RECIP_M);
			end
			MUL_CORR: begin
				// quotient estimate straight from the reciprocal product
				mul_a = signed'({14'd0, prod_q[61:44]});
				mul_b = signed'(32'(SENSOR_SPAN));
			end
			MUL_FILT: begin
				mul_a = signed'({15'd0, gain_eff});
				mul_b = 32'(conv_q) - signed'({16'd0, est_q});
			end
			MUL_SETP: begin
				mul_a = signed'({16'd0, cfg.sp_ceil});
				mul_b = signed'({15'd0, act_eff});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// quotient correction: estimate is low by at most one
	assign rem    = xoff_q - prod_q[30:0];
	assign quo    = (rem >= 31'(SENSOR_SPAN)) ? qest_q + 18'd1 : qest_q;
	assign conv_d = signed'({1'b0, quo}) - signed'(19'(CONV_BIAS));

	// filter: g*(c-old) + old*one + half, then clamp
	assign acc = signed'(prod_q[39:0]) + signed'({8'd0, est_q, 16'h8000});
	always_comb begin
		if (acc[39]) begin
			filt_d = '0;
		end else if (acc[39:32] != 8'd0) begin
			filt_d = '1;
		end else begin
			filt_d = acc[31:16];
		end
	end

	// setpoint with rounding and clamp, max bound wins
	assign sp_sum = prod_q[33:0] + 34'd32768;
	assign sp_raw = sp_sum[33:16];
	assign sp_lo  = (sp_raw < {2'd0, cfg.sp_floor}) ? cfg.sp_floor : sp_raw[15:0];
	assign sp     = (sp_lo > cfg.sp_ceil) ? cfg.sp_ceil : sp_lo;

	// deadband
	assign diff    = signed'({2'd0, filt_q}) - signed'({2'd0, sp});
	assign mag     = diff[17] ? 18'(-diff) : 18'(diff);
	assign in_band = mag <= {2'd0, cfg.tolerance};
	assign skip    = reached_q && (held_q == sp) && stop_q;

	always_comb begin
		priority if (skip || in_band) begin
			vcmd_d = VALVE_HOLD;
		end else if (diff[17]) begin
			vcmd_d = VALVE_INFLATE;
		end else begin
			vcmd_d = VALVE_VACUUM;
		end
	end

	// valve image, vacuum write after inflate write
	always_comb begin
		for (int j = 0; j < IMG_WIDTH; j++) begin
			img_d[j] = img_q[j];
			if (j < IMG_LIMIT) begin
				if (cfg.inflate_bit == POS_W'(j + 1)) begin
					img_d[j] = (vcmd_d == VALVE_INFLATE);
				end
				if (cfg.vacuum_bit == POS_W'(j + 1)) begin
					img_d[j] = (vcmd_d == VALVE_VACUUM);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q  <= raw_sample;
			act_q  <= activation;
			stop_q <= stop_when_reached;
		end
		if (cmd.mul_en) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		if (cmd.mul_en && cmd.op == MUL_RECIP) begin
			xoff_q <= xoff_d;
		end
		if (cmd.mul_en && cmd.op == MUL_CORR) begin
			qest_q <= prod_q[61:44];
		end
		if (cmd.quo_en) begin
			conv_q <= conv_d;
		end
		if (cmd.filt_en) begin
			filt_q <= filt_d;
		end
		if (cmd.commit) begin
			vcmd_q <= vcmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q     <= '0;
			held_q    <= '0;
			reached_q <= 1'b0;
			img_q     <= '0;
		end else if (cmd.commit) begin
			est_q <= filt_q;
			img_q <= img_d;
			if (!skip) begin
				held_q    <= sp;
				reached_q <= in_band;
			end
		end
	end

	assign valve_command     = vcmd_q;
	assign filtered_pressure = est_q;
	assign active_setpoint   = held_q;
	assign reached           = reached_q;
	assign shift_image       = img_q;

endmodule

@@ rtl/pneumatic_bang_bang_regulator_top.sv @@
// Bang-bang pressure regulator with deadband. Each sample beat carries a 14-bit sensor
// code, a Q1.16 demand and a stop flag; the block converts the code to Q8.8 psi, runs
// it through an exponentially weighted filter, forms a clamped setpoint, and decides
// hold, inflate or vacuum, returning one result beat per sample with the filtered
// pressure, setpoint, reached flag and a 32-bit valve shift-register image. Each sample
// passes in turn through the single shared 32x32 multiplier, used five times (scale,
// reciprocal divide, divide correction, filter, setpoint), with a quotient fix-up step
// after the divide correction and a decision step at the end that latches the result;
// a new sample is taken in the cycle after the previous result is latched, while that
// result may still be waiting downstream.
// Configuration beats are taken every cycle and must only be sent while the block is idle.
module pneumatic_bang_bang_regulator_top (
	input logic  clk,
	input logic  arst_n,
	bbr_cfg_if.sink    cfg,
	bbr_in_if.sink     sample,
	bbr_out_if.source  result
);
	import bbr_pkg::*;

	cfg_t     cfg_q;
	bbr_cmd_t cmd;

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sp_floor    <= 16'd0;
			cfg_q.sp_ceil     <= 16'd1280;
			cfg_q.tolerance   <= 16'd26;
			cfg_q.filter_gain <= ONE_Q16;
			cfg_q.full_scale  <= 16'd3840;
			cfg_q.inflate_bit <= 6'd1;
			cfg_q.vacuum_bit  <= 6'd2;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MIN_PRESSURE: cfg_q.sp_floor    <= cfg.data[PRS_W-1:0];
				REG_MAX_PRESSURE: cfg_q.sp_ceil     <= cfg.data[PRS_W-1:0];
				REG_TOLERANCE:    cfg_q.tolerance   <= cfg.data[PRS_W-1:0];
				REG_FILTER_GAIN:  cfg_q.filter_gain <= cfg.data;
				REG_FULL_SCALE:   cfg_q.full_scale  <= cfg.data[PRS_W-1:0];
				REG_INFLATE_BIT:  cfg_q.inflate_bit <= cfg.data[POS_W-1:0];
				REG_VACUUM_BIT:   cfg_q.vacuum_bit  <= cfg.data[POS_W-1:0];
				// unused index, beat dropped
				default: ;
			endcase
		end
	end

	// sequencer: one sample in flight, result slot tracked here
	bbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// arithmetic, regulator state and result registers
	bbr_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.cmd               (cmd),
		.raw_sample        (sample.raw_sample),
		.activation        (sample.activation),
		.stop_when_reached (sample.stop_when_reached),
		.valve_command     (result.valve_command),
		.filtered_pressure (result.filtered_pressure),
		.active_setpoint   (result.active_setpoint),
		.reached           (result.reached),
		.shift_image       (result.shift_image)
	);

endmodule
